// ----- rtl/sse_pkg.sv -----
// sample statistics engine: shared types and constants
// word layouts for both channels and the sequencer state type; no dependencies
package sse_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_W    = 8;
    localparam int FIX_W     = 24;
    localparam int CNT_OUT_W = 6;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                is_last;
    } t_sse_in;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] sample_count;
        logic [SAMPLE_W-1:0]  largest;
        logic [SAMPLE_W-1:0]  smallest;
        logic [SAMPLE_W-1:0]  spread;
        logic [FIX_W-1:0]     mean_fixed;
        logic [FIX_W-1:0]     mean_abs_dev_fixed;
    } t_sse_out;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_DEV,
        ST_DEV_GO,
        ST_DEV_WAIT,
        ST_OUT
    } t_sse_state;

endpackage

// ----- rtl/sse_channels.sv -----
// sample statistics engine: valid/ready channel interfaces
// depends on sse_pkg for the word layouts
interface sse_in_if;
    logic             valid;
    logic             ready;
    sse_pkg::t_sse_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sse_out_if;
    logic              valid;
    logic              ready;
    sse_pkg::t_sse_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sample_statistics_engine_unit.sv -----
// sample statistics engine: top level with sequencer and datapath
// depends on sse_pkg, sse_channels, sse_store and sse_divider
//
// usage: samples arrive one word per cycle on i_smp; each is written to the
// store while count, sum, maximum and minimum are updated on the fly. the word
// flagged is_last, or the one that fills the store, closes the set. the block
// then drops ready and works out the statistics: the mean through the shared
// bit-serial divider (DVD_W = 24 + count width, 30 for 32 samples), a pass
// over the store accumulating |mean - sample| (one memory read a cycle), and
// a second run of the same divider for the deviation. one result word then
// sits on o_res. while o_res is stalled the result holds and no new sample
// is taken; the next set starts the cycle after the result word is taken.
// reset (synchronous, active low) empties the set and idles the sequencer;
// memory contents are not cleared, only entries written in the current set
// are ever read back.
module sample_statistics_engine_unit #(
    parameter int MAX_SAMPLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sse_in_if.sink      i_smp,
    sse_out_if.source   o_res
);

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SW    = sse_pkg::SAMPLE_W + CW;
    localparam int DVD_W = sse_pkg::FIX_W + CW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

    sse_pkg::t_sse_state r_state, n_state;

    logic [CW-1:0]                r_cnt, n_cnt;
    logic [SW-1:0]                r_sum, n_sum;
    logic [sse_pkg::SAMPLE_W-1:0] r_max, n_max;
    logic [sse_pkg::SAMPLE_W-1:0] r_min, n_min;
    logic [sse_pkg::FIX_W-1:0]    r_mean, n_mean;
    logic [DVD_W-1:0]             r_dev, n_dev;
    logic [CW-1:0]                r_idx, n_idx;
    logic                         r_rd_vld, n_rd_vld;
    sse_pkg::t_sse_out            r_res, n_res;

    logic                         in_acc, out_acc, set_end;
    logic                         div_start, div_busy, div_done;
    logic [DVD_W-1:0]             div_dividend, div_quo;
    logic                         issue;
    logic [sse_pkg::SAMPLE_W-1:0] rd_data;
    logic [sse_pkg::FIX_W-1:0]    x_fix;
    logic [sse_pkg::FIX_W:0]      diff;
    logic [sse_pkg::FIX_W-1:0]    abs_diff;
    logic [sse_pkg::SAMPLE_W-1:0] smp;

    assign smp     = i_smp.data.sample;
    assign in_acc  = i_smp.valid && i_smp.ready;
    assign out_acc = o_res.valid && o_res.ready;
    assign set_end = i_smp.data.is_last || (r_cnt + CW'(1) == MAX_CNT);
    assign issue   = (r_idx != r_cnt);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sse_pkg::ST_LOAD: begin
                if (in_acc && set_end) n_state = sse_pkg::ST_MEAN_GO;
            end
            sse_pkg::ST_MEAN_GO:   n_state = sse_pkg::ST_MEAN_WAIT;
            sse_pkg::ST_MEAN_WAIT: begin
                if (div_done) n_state = sse_pkg::ST_DEV;
            end
            sse_pkg::ST_DEV: begin
                if (!issue && !r_rd_vld) n_state = sse_pkg::ST_DEV_GO;
            end
            sse_pkg::ST_DEV_GO:    n_state = sse_pkg::ST_DEV_WAIT;
            sse_pkg::ST_DEV_WAIT: begin
                if (div_done) n_state = sse_pkg::ST_OUT;
            end
            sse_pkg::ST_OUT: begin
                if (out_acc) n_state = sse_pkg::ST_LOAD;
            end
            default: n_state = sse_pkg::ST_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_smp.ready  = 1'b0;
        o_res.valid  = 1'b0;
        div_start    = 1'b0;
        div_dividend = DVD_W'({r_sum, {sse_pkg::FRAC_W{1'b0}}});
        case (r_state)
            sse_pkg::ST_LOAD:    i_smp.ready = 1'b1;
            sse_pkg::ST_MEAN_GO: div_start   = 1'b1;
            sse_pkg::ST_DEV_GO: begin
                div_start    = 1'b1;
                div_dividend = r_dev;
            end
            sse_pkg::ST_OUT:     o_res.valid = 1'b1;
            default: ;
        endcase
    end

    // absolute difference against the truncated mean
    always_comb begin
        x_fix    = {rd_data, {sse_pkg::FRAC_W{1'b0}}};
        diff     = {1'b0, r_mean} - {1'b0, x_fix};
        abs_diff = diff[sse_pkg::FIX_W] ? (x_fix - r_mean) : diff[sse_pkg::FIX_W-1:0];
    end

    // datapath
    always_comb begin
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_max    = r_max;
        n_min    = r_min;
        n_mean   = r_mean;
        n_dev    = r_dev;
        n_idx    = r_idx;
        n_rd_vld = 1'b0;
        n_res    = r_res;
        case (r_state)
            sse_pkg::ST_LOAD: begin
                if (in_acc) begin
                    n_cnt = r_cnt + CW'(1);
                    n_sum = r_sum + SW'(smp);
                    if (smp > r_max) n_max = smp;
                    if (smp < r_min) n_min = smp;
                end
            end
            sse_pkg::ST_MEAN_WAIT: begin
                if (div_done) begin
                    n_mean = div_quo[sse_pkg::FIX_W-1:0];
                    n_dev  = '0;
                    n_idx  = '0;
                end
            end
            sse_pkg::ST_DEV: begin
                n_rd_vld = issue;
                if (issue) n_idx = r_idx + CW'(1);
                if (r_rd_vld) n_dev = r_dev + DVD_W'(abs_diff);
            end
            sse_pkg::ST_DEV_WAIT: begin
                if (div_done) begin
                    n_res.sample_count       = sse_pkg::CNT_OUT_W'(r_cnt);
                    n_res.largest            = r_max;
                    n_res.smallest           = r_min;
                    n_res.spread             = r_max - r_min;
                    n_res.mean_fixed         = r_mean;
                    n_res.mean_abs_dev_fixed = div_quo[sse_pkg::FIX_W-1:0];
                end
            end
            sse_pkg::ST_OUT: begin
                if (out_acc) begin
                    n_cnt = '0;
                    n_sum = '0;
                    n_max = '0;
                    n_min = '1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sse_pkg::ST_LOAD;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_max    <= '0;
            r_min    <= '1;
            r_dev    <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_max    <= n_max;
            r_min    <= n_min;
            r_dev    <= n_dev;
            r_idx    <= n_idx;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mean <= n_mean;
        r_res  <= n_res;
    end

    assign o_res.data = r_res;

    sse_store #(
        .DEPTH  (MAX_SAMPLES),
        .DATA_W (sse_pkg::SAMPLE_W),
        .ADDR_W (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (smp),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    sse_divider #(
        .DVD_W (DVD_W),
        .DVR_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_cnt),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // no sample may be taken while a division is in flight
    a_no_load_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> !i_smp.ready)
        else $error("sample accepted during division");

    // the set never grows past the store
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("sample count beyond store depth");

    // a closing word always leads into the mean division next cycle
    a_set_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && set_end) |=> (r_state == sse_pkg::ST_MEAN_GO))
        else $error("set end not followed by mean division");

    // the mean lies between the smallest and largest samples
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.mean_fixed >= {o_res.data.smallest, 8'h00}) &&
                        (o_res.data.mean_fixed <= {o_res.data.largest, 8'h00}))
        else $error("mean outside sample range");

    // a set always holds at least one sample when the result is shown
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_cnt != '0))
        else $error("result for empty set");

endmodule

// ----- rtl/sse_store.sv -----
// sample statistics engine: sample memory
// one write port, one read port with registered read data; no dependencies
module sse_store #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sse_divider.sv -----
// sample statistics engine: restoring divider, one quotient bit per cycle
// shared by the mean and the deviation divisions; no dependencies
module sse_divider #(
    parameter int DVD_W = 30,
    parameter int DVR_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVR_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DVR_W-1:0]  r_rem, n_rem;
    logic [DVD_W-1:0]  r_quo, n_quo;
    logic [DVR_W-1:0]  r_dvs, n_dvs;

    logic [DVR_W:0]    shifted;
    logic [DVR_W+1:0]  trial;
    logic              fits;

    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_dvs};
        fits    = !trial[DVR_W+1];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(DVD_W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem  = fits ? trial[DVR_W-1:0] : shifted[DVR_W-1:0];
            n_quo  = {r_quo[DVD_W-2:0], fits};
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- tb/sse_stats_checker.sv -----
// sample statistics engine: checker that watches both channels and predicts results
// depends on sse_pkg and the channel interfaces in sse_channels
module sse_stats_checker #(
    parameter int MAX_SAMPLES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sse_in_if    i_smp,
    sse_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_W = 21;
    localparam int ACC_W = 29;

    logic [sse_pkg::SAMPLE_W-1:0]  held_samples [MAX_SAMPLES];
    logic [sse_pkg::CNT_OUT_W-1:0] held_count;
    logic [SUM_W-1:0]              sum_so_far;
    logic [sse_pkg::SAMPLE_W-1:0]  max_so_far;
    logic [sse_pkg::SAMPLE_W-1:0]  min_so_far;

    sse_pkg::t_sse_out stats_due[$];
    int                mismatches = 0;
    int                stats_left = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = stats_left;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [sse_pkg::FIX_W-1:0] got,
                               input logic [sse_pkg::FIX_W-1:0] want);
        if (got !== want)
            report($sformatf("%s got %0d want %0d", field, got, want));
    endtask

    task automatic clear_set();
        held_count = '0;
        sum_so_far = '0;
        max_so_far = '0;
        min_so_far = '1;
    endtask

    // one accepted sample word; closes the set on is_last or a full store
    task automatic absorb_sample(input logic [sse_pkg::SAMPLE_W-1:0] smp,
                                 input logic last);
        logic [ACC_W-1:0]  mean_w;
        logic [ACC_W-1:0]  dev_acc;
        logic [ACC_W-1:0]  scaled;
        logic [ACC_W-1:0]  dev_q;
        sse_pkg::t_sse_out stats;
        if (held_count < MAX_SAMPLES) begin
            held_samples[held_count] = smp;
            held_count = held_count + 1'b1;
        end
        sum_so_far = sum_so_far + smp;
        if (smp > max_so_far)
            max_so_far = smp;
        if (smp < min_so_far)
            min_so_far = smp;
        if (!last && held_count < MAX_SAMPLES)
            return;
        mean_w  = {sum_so_far, {sse_pkg::FRAC_W{1'b0}}} / ACC_W'(held_count);
        dev_acc = '0;
        // deviation is taken against the truncated fixed point mean
        for (int i = 0; i < held_count; i++) begin
            scaled = ACC_W'({held_samples[i], {sse_pkg::FRAC_W{1'b0}}});
            dev_acc += (mean_w >= scaled) ? (mean_w - scaled) : (scaled - mean_w);
        end
        dev_q = dev_acc / ACC_W'(held_count);
        stats.sample_count       = held_count;
        stats.largest            = max_so_far;
        stats.smallest           = min_so_far;
        stats.spread             = max_so_far - min_so_far;
        stats.mean_fixed         = mean_w[sse_pkg::FIX_W-1:0];
        stats.mean_abs_dev_fixed = dev_q[sse_pkg::FIX_W-1:0];
        stats_due.push_back(stats);
        clear_set();
    endtask

    always @(posedge i_clk) begin
        sse_pkg::t_sse_out want;
        sse_pkg::t_sse_out got;
        if (!i_rst_n) begin
            clear_set();
            stats_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (stats_due.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    want = stats_due.pop_front();
                    check_field("sample_count", sse_pkg::FIX_W'(got.sample_count),
                                sse_pkg::FIX_W'(want.sample_count));
                    check_field("largest", sse_pkg::FIX_W'(got.largest),
                                sse_pkg::FIX_W'(want.largest));
                    check_field("smallest", sse_pkg::FIX_W'(got.smallest),
                                sse_pkg::FIX_W'(want.smallest));
                    check_field("spread", sse_pkg::FIX_W'(got.spread),
                                sse_pkg::FIX_W'(want.spread));
                    check_field("mean_fixed", got.mean_fixed, want.mean_fixed);
                    check_field("mean_abs_dev_fixed", got.mean_abs_dev_fixed,
                                want.mean_abs_dev_fixed);
                end
            end
            if (i_smp.valid && i_smp.ready)
                absorb_sample(i_smp.data.sample, i_smp.data.is_last);
        end
        stats_left = stats_due.size();
    end

endmodule

// ----- tb/sample_statistics_engine_unit_tb.sv -----
// sample statistics engine: testbench top, stimulus and verdict
// depends on sse_pkg, sse_channels, the engine rtl and sse_stats_checker
module sample_statistics_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SAMPLES  = 32;
    localparam int RANDOM_WORDS = 1850;
    localparam int QUIET_FROM   = 5000;
    localparam int QUIET_TO     = 9000;
    localparam int HOLD_AT      = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cyc = 0;
    int   words_sent = 0;
    int   fail_count;
    int   pending;

    sse_in_if  smp ();
    sse_out_if res ();

    sample_statistics_engine_unit #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res)
    );

    sse_stats_checker #(.MAX_SAMPLES(MAX_SAMPLES)) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_smp        (smp),
        .i_res        (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) cyc <= cyc + 1;

    function automatic bit quiet_now();
        return cyc >= QUIET_FROM && cyc < QUIET_TO;
    endfunction

    // holds the word until the engine takes it; idles now and then beforehand
    task automatic send_word(input logic [sse_pkg::SAMPLE_W-1:0] s, input logic last);
        while (!quiet_now() && $urandom_range(0, 99) < 7) begin
            smp.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp.valid <= 1'b1;
        smp.data  <= '{sample: s, is_last: last};
        @(posedge i_clk);
        while (!smp.ready)
            @(posedge i_clk);
        words_sent++;
    endtask

    function automatic logic [sse_pkg::SAMPLE_W-1:0] pick_sample(
        input logic [sse_pkg::SAMPLE_W-1:0] base,
        input bit clustered
    );
        int r;
        r = $urandom_range(0, 9);
        if (clustered)
            return (base > 16'hFFF0) ? base - sse_pkg::SAMPLE_W'($urandom_range(0, 7))
                                     : base + sse_pkg::SAMPLE_W'($urandom_range(0, 7));
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return sse_pkg::SAMPLE_W'($urandom);
    endfunction

    // stimulus
    initial begin
        int                           set_len;
        int                           kind;
        bit                           flag_end;
        bit                           clustered;
        logic [sse_pkg::SAMPLE_W-1:0] base;
        i_rst_n   <= 1'b0;
        smp.valid <= 1'b0;
        smp.data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single sample sets at both extremes
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b1);
        // widest spread
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0001, 1'b1);
        // equal samples give zero deviation
        repeat (3) send_word(16'h0007, 1'b0);
        send_word(16'h0007, 1'b1);
        // store full with no last flag closes the set
        for (int i = 0; i < MAX_SAMPLES; i++)
            send_word(i[0] ? 16'hFFFF : 16'h0000, 1'b0);

        while (words_sent < RANDOM_WORDS + 42) begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
                set_len = $urandom_range(1, 8);
            else if (kind < 80)
                set_len = $urandom_range(9, 31);
            else
                set_len = MAX_SAMPLES;
            // a full set may or may not carry the last flag on its final word
            flag_end  = (kind < 90);
            clustered = ($urandom_range(0, 4) == 0);
            base      = sse_pkg::SAMPLE_W'($urandom);
            for (int i = 0; i < set_len; i++)
                send_word(pick_sample(base, clustered), (i == set_len - 1) && flag_end);
        end
        smp.valid <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off so the engine backs up
    initial begin
        res.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (cyc == HOLD_AT) begin
                repeat (HOLD_CYCLES) begin
                    res.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            res.ready <= quiet_now() || ($urandom_range(0, 99) >= 7);
        end
    end

    initial begin
        #50ms;
        $display("status: fail");
        $finish;
    end

endmodule
